### hw/rtl/oblm_pkg.sv
// Package for the order book cross/lock monitor.
// Holds report codes, opcodes, state enums and the front-to-back command struct.
// No dependencies.
`default_nettype none
package oblm_pkg;

    localparam logic [1:0] KIND_CROSSED = 2'd0;
    localparam logic [1:0] KIND_LOCKED  = 2'd1;
    localparam logic [1:0] KIND_NORMAL  = 2'd2;
    localparam logic [1:0] KIND_EMPTY   = 2'd3;

    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_MODIFY = 1'b1;

    localparam logic [1:0] REG_PRICE_TOLERANCE = 2'd0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_SCAN,
        ST_EVAL,
        ST_CLEAR
    } back_state_t;

    typedef struct packed {
        logic        opcode;
        logic        side_is_ask;
        logic [31:0] order_size;
        logic [31:0] order_price;
        logic [47:0] event_time;
    } cmd_pay_t;

endpackage
`default_nettype wire

### hw/rtl/oblm_cmd_fifo.sv
// Short command queue between the front part and the back engine.
// Depends on oblm_pkg for the payload struct.
`default_nettype none
module oblm_cmd_fifo #(
    parameter int SYM_W  = 4,
    parameter int SLOT_W = 10
) (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     in_valid,
    output logic                    in_ready,
    input  oblm_pkg::cmd_pay_t      in_pay,
    input  wire [SYM_W-1:0]         in_sym,
    input  wire [SLOT_W-1:0]        in_slot,
    output logic                    out_valid,
    input  wire                     out_ready,
    output oblm_pkg::cmd_pay_t      out_pay,
    output logic [SYM_W-1:0]        out_sym,
    output logic [SLOT_W-1:0]       out_slot
);
    oblm_pkg::cmd_pay_t  pay_reg [2];
    logic [SYM_W-1:0]    sym_reg [2];
    logic [SLOT_W-1:0]   slot_reg [2];
    logic                wp_reg, rp_reg;
    logic [1:0]          cnt_reg;
    logic                push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;
    assign out_pay  = pay_reg[rp_reg];
    assign out_sym  = sym_reg[rp_reg];
    assign out_slot = slot_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            pay_reg[wp_reg]  <= in_pay;
            sym_reg[wp_reg]  <= in_sym;
            slot_reg[wp_reg] <= in_slot;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

### hw/rtl/oblm_front.sv
// Front part: takes input transfers, folds indices and queues commands.
// Depends on oblm_pkg and oblm_cmd_fifo.
`default_nettype none
module oblm_front #(
    parameter int SYM_W  = 4,
    parameter int SLOT_W = 10,
    parameter int NUM_SYMBOLS = 16,
    parameter int ORDER_SLOTS = 1024
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  wire                 s_opcode,
    input  wire                 s_side_is_ask,
    input  wire [3:0]           s_symbol_index,
    input  wire [9:0]           s_order_slot,
    input  wire [31:0]          s_order_size,
    input  wire [31:0]          s_order_price,
    input  wire [47:0]          s_event_time,
    output logic                c_valid,
    input  wire                 c_ready,
    output oblm_pkg::cmd_pay_t  c_pay,
    output logic [SYM_W-1:0]    c_sym,
    output logic [SLOT_W-1:0]   c_slot
);
    oblm_pkg::cmd_pay_t  pay;
    logic [SYM_W-1:0]    sym;
    logic [SLOT_W-1:0]   slot;

    always_comb begin
        pay.opcode      = s_opcode;
        pay.side_is_ask = s_side_is_ask;
        pay.order_size  = s_order_size;
        pay.order_price = s_order_price;
        pay.event_time  = s_event_time;
        sym  = SYM_W'(32'(s_symbol_index) % NUM_SYMBOLS);
        slot = SLOT_W'(32'(s_order_slot) % ORDER_SLOTS);
    end

    oblm_cmd_fifo #(.SYM_W(SYM_W), .SLOT_W(SLOT_W)) u_fifo (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_valid), .in_ready(s_ready),
        .in_pay(pay), .in_sym(sym), .in_slot(slot),
        .out_valid(c_valid), .out_ready(c_ready),
        .out_pay(c_pay), .out_sym(c_sym), .out_slot(c_slot)
    );
endmodule
`default_nettype wire

### hw/rtl/oblm_back.sv
// Back engine: order table memory, best-price rescan and market evaluation.
// Depends on oblm_pkg.
`default_nettype none
module oblm_back #(
    parameter int SYM_W  = 4,
    parameter int SLOT_W = 10,
    parameter int NUM_SYMBOLS = 16,
    parameter int ORDER_SLOTS = 1024
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire [7:0]           tol,
    output logic                busy,
    input  wire                 c_valid,
    output logic                c_ready,
    input  oblm_pkg::cmd_pay_t  c_pay,
    input  wire [SYM_W-1:0]     c_sym,
    input  wire [SLOT_W-1:0]    c_slot,
    output logic                m_valid,
    input  wire                 m_ready,
    output logic [47:0]         m_report_time,
    output logic [3:0]          m_report_symbol,
    output logic [1:0]          m_report_kind,
    output logic [31:0]         m_top_bid,
    output logic [31:0]         m_top_ask
);
    localparam int ENT_W = 1 + 1 + SYM_W + 32;

    // Memory entry: valid, side, symbol, price. Quantity is never read back.
    logic [ENT_W-1:0]  mem [ORDER_SLOTS];
    logic [ENT_W-1:0]  rd_reg;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr, rd_addr;
    logic [ENT_W-1:0]  wr_data;

    oblm_pkg::back_state_t state_reg, state_next;
    oblm_pkg::cmd_pay_t    cmd_reg;
    logic [SYM_W-1:0]      sym_reg, sym2_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic                  two_reg, pass_reg;
    logic [SLOT_W:0]       idx_reg;
    logic                  rdv_reg;
    logic [SLOT_W-1:0]     rdi_reg;
    logic [32:0]           bb_reg, ba_reg;
    logic [NUM_SYMBOLS-1:0] abn_reg;
    logic [32:0]           bid_c [NUM_SYMBOLS];
    logic [32:0]           ask_c [NUM_SYMBOLS];
    logic                  lk_reg;

    logic                  r_valid, r_side;
    logic [SYM_W-1:0]      r_sym;
    logic [31:0]           r_price;
    logic                  scan_last;

    assign {r_valid, r_side, r_sym, r_price} = rd_reg;
    assign busy    = (state_reg != oblm_pkg::ST_IDLE) || m_valid;
    assign c_ready = (state_reg == oblm_pkg::ST_IDLE) && !m_valid;
    assign scan_last = rdv_reg && (rdi_reg == SLOT_W'(ORDER_SLOTS - 1));

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            oblm_pkg::ST_IDLE:   if (c_valid && c_ready) state_next = oblm_pkg::ST_LOOKUP;
            oblm_pkg::ST_LOOKUP: begin
                if (lk_reg) begin
                    if (cmd_reg.opcode == oblm_pkg::OP_MODIFY && !r_valid)
                        state_next = oblm_pkg::ST_IDLE;
                    else
                        state_next = oblm_pkg::ST_SCAN;
                end
            end
            oblm_pkg::ST_SCAN:   if (scan_last && !(two_reg && !pass_reg))
                                     state_next = oblm_pkg::ST_EVAL;
            oblm_pkg::ST_EVAL:   state_next = oblm_pkg::ST_IDLE;
            oblm_pkg::ST_CLEAR:  if (idx_reg == (SLOT_W+1)'(ORDER_SLOTS - 1))
                                     state_next = oblm_pkg::ST_IDLE;
            default:             state_next = oblm_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = slot_reg;
        wr_data = {1'b1, cmd_reg.side_is_ask, sym_reg, cmd_reg.order_price};
        rd_addr = slot_reg;
        unique case (state_reg)
            oblm_pkg::ST_IDLE:   rd_addr = c_slot;
            oblm_pkg::ST_LOOKUP: begin
                rd_addr = slot_reg;
                if (lk_reg && (cmd_reg.opcode == oblm_pkg::OP_ADD || r_valid)) begin
                    wr_en = 1'b1;
                    if (cmd_reg.opcode == oblm_pkg::OP_ADD)
                        wr_data = {1'b1, cmd_reg.side_is_ask, sym_reg, cmd_reg.order_price};
                    else if (cmd_reg.order_size == 32'd0)
                        wr_data = {1'b0, r_side, r_sym, r_price};
                    else
                        wr_data = {1'b1, r_side, r_sym, cmd_reg.order_price};
                end
            end
            oblm_pkg::ST_SCAN:   rd_addr = idx_reg[SLOT_W-1:0];
            oblm_pkg::ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = idx_reg[SLOT_W-1:0];
                wr_data = '0;
            end
            default:             rd_addr = slot_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        rd_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= oblm_pkg::ST_CLEAR;
            idx_reg   <= '0;
            abn_reg   <= '0;
            m_valid   <= 1'b0;
            lk_reg    <= 1'b0;
            rdv_reg   <= 1'b0;
            for (int i = 0; i < NUM_SYMBOLS; i++) begin
                bid_c[i] <= '0;
                ask_c[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (m_valid && m_ready) m_valid <= 1'b0;
            unique case (state_reg)
                oblm_pkg::ST_CLEAR: begin
                    idx_reg <= idx_reg + 1'b1;
                end
                oblm_pkg::ST_IDLE: begin
                    if (c_valid && c_ready) begin
                        cmd_reg  <= c_pay;
                        sym_reg  <= c_sym;
                        slot_reg <= c_slot;
                        lk_reg   <= 1'b0;
                    end
                end
                oblm_pkg::ST_LOOKUP: begin
                    if (!lk_reg) begin
                        lk_reg <= 1'b1;
                    end else begin
                        idx_reg  <= '0;
                        rdv_reg  <= 1'b0;
                        pass_reg <= 1'b0;
                        bb_reg   <= '0;
                        ba_reg   <= '0;
                        two_reg  <= (cmd_reg.opcode == oblm_pkg::OP_ADD) && r_valid
                                    && (r_sym != sym_reg);
                        if (cmd_reg.opcode == oblm_pkg::OP_ADD) begin
                            sym2_reg <= sym_reg;
                            if (r_valid && r_sym != sym_reg) sym_reg <= r_sym;
                        end else if (!r_valid) begin
                            m_valid         <= 1'b1;
                            m_report_time   <= cmd_reg.event_time;
                            m_report_symbol <= '0;
                            m_report_kind   <= oblm_pkg::KIND_EMPTY;
                            m_top_bid       <= '0;
                            m_top_ask       <= '0;
                        end else begin
                            sym_reg  <= r_sym;
                            sym2_reg <= r_sym;
                        end
                    end
                end
                oblm_pkg::ST_SCAN: begin
                    rdi_reg <= idx_reg[SLOT_W-1:0];
                    if (scan_last && two_reg && !pass_reg) begin
                        pass_reg <= 1'b1;
                        sym_reg  <= sym2_reg;
                        idx_reg  <= '0;
                        rdv_reg  <= 1'b0;
                        bb_reg   <= '0;
                        ba_reg   <= '0;
                    end else begin
                        if (idx_reg < (SLOT_W+1)'(ORDER_SLOTS)) idx_reg <= idx_reg + 1'b1;
                        rdv_reg <= (idx_reg < (SLOT_W+1)'(ORDER_SLOTS));
                        if (rdv_reg && r_valid && r_sym == sym_reg) begin
                            if (r_side) begin
                                if (!ba_reg[32] || r_price < ba_reg[31:0])
                                    ba_reg <= {1'b1, r_price};
                            end else begin
                                if (!bb_reg[32] || r_price > bb_reg[31:0])
                                    bb_reg <= {1'b1, r_price};
                            end
                        end
                    end
                    if (scan_last) begin
                        bid_c[sym_reg] <= (rdv_reg && r_valid && r_sym == sym_reg && !r_side
                            && (!bb_reg[32] || r_price > bb_reg[31:0])) ? {1'b1, r_price} : bb_reg;
                        ask_c[sym_reg] <= (rdv_reg && r_valid && r_sym == sym_reg && r_side
                            && (!ba_reg[32] || r_price < ba_reg[31:0])) ? {1'b1, r_price} : ba_reg;
                    end
                end
                oblm_pkg::ST_EVAL: begin
                    if (!abn_reg[sym_reg]) begin
                        if (bid_c[sym_reg][32] && ask_c[sym_reg][32]) begin
                            if (ask_c[sym_reg][31:0] < bid_c[sym_reg][31:0]) begin
                                abn_reg[sym_reg] <= 1'b1;
                                m_valid <= 1'b1;
                                m_report_kind <= oblm_pkg::KIND_CROSSED;
                            end else if ({1'b0, ask_c[sym_reg][31:0]}
                                         <= {1'b0, bid_c[sym_reg][31:0]} + 33'(tol)) begin
                                abn_reg[sym_reg] <= 1'b1;
                                m_valid <= 1'b1;
                                m_report_kind <= oblm_pkg::KIND_LOCKED;
                            end
                        end
                    end else if (!(bid_c[sym_reg][32] && ask_c[sym_reg][32])
                                 || {1'b0, ask_c[sym_reg][31:0]}
                                    > {1'b0, bid_c[sym_reg][31:0]} + 33'(tol)) begin
                        abn_reg[sym_reg] <= 1'b0;
                        m_valid <= 1'b1;
                        m_report_kind <= oblm_pkg::KIND_NORMAL;
                    end
                    m_report_time   <= cmd_reg.event_time;
                    m_report_symbol <= 4'(sym_reg);
                    m_top_bid       <= bid_c[sym_reg][31:0];
                    m_top_ask       <= ask_c[sym_reg][31:0];
                end
                default: ;
            endcase
        end
    end

    property p_out_hold;
        @(posedge aclk) disable iff (!aresetn) m_valid && !m_ready |=> m_valid;
    endproperty
    a_out_hold: assert property (p_out_hold) else $error("result dropped");

    a_no_take_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        c_ready |-> state_reg == oblm_pkg::ST_IDLE && !m_valid)
        else $error("command taken while busy");

    a_empty_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) && m_report_kind == oblm_pkg::KIND_EMPTY |-> m_report_symbol == 4'd0)
        else $error("empty-slot report with symbol");
endmodule
`default_nettype wire

### hw/rtl/order_book_cross_lock_monitor.sv
// Top level of the order book cross/lock monitor: APB register, front, back.
// Depends on oblm_pkg, oblm_front, oblm_back.
//
// channel | direction | handshake       | payload
// s_      | in        | s_valid/s_ready | opcode, side, symbol, slot, size, price, time
// m_      | out       | m_valid/m_ready | time, symbol, kind, top bid, top ask
// apb     | in        | psel/penable    | price_tolerance at address 0
//
// An add, or a modify of a live slot, rescans the whole order table, twice when
// an add moves a slot to another symbol; no new command is taken until it is through.
// An empty-slot modify skips the scan. Reset is synchronous; after it a clearing
// pass over all ORDER_SLOTS entries empties the table before the first command.
// A stalled m_ side holds the back engine; the front queue takes up to two
// further transfers.
`default_nettype none
module order_book_cross_lock_monitor #(
    parameter int NUM_SYMBOLS = 16,
    parameter int ORDER_SLOTS = 1024
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [1:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire         s_opcode,
    input  wire         s_side_is_ask,
    input  wire  [3:0]  s_symbol_index,
    input  wire  [9:0]  s_order_slot,
    input  wire  [31:0] s_order_size,
    input  wire  [31:0] s_order_price,
    input  wire  [47:0] s_event_time,
    output logic        m_valid,
    input  wire         m_ready,
    output logic [47:0] m_report_time,
    output logic [3:0]  m_report_symbol,
    output logic [1:0]  m_report_kind,
    output logic [31:0] m_top_bid,
    output logic [31:0] m_top_ask
);
    localparam int SYM_W  = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
    localparam int SLOT_W = $clog2(ORDER_SLOTS);

    logic [7:0]             tol_reg;
    logic                   c_valid, c_ready, busy;
    oblm_pkg::cmd_pay_t     c_pay;
    logic [SYM_W-1:0]       c_sym;
    logic [SLOT_W-1:0]      c_slot;

    assign pready = 1'b1;
    assign prdata = (paddr == oblm_pkg::REG_PRICE_TOLERANCE) ? {24'd0, tol_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= '0;
        end else if (psel && penable && pwrite && paddr == oblm_pkg::REG_PRICE_TOLERANCE) begin
            tol_reg <= pwdata[7:0];
        end
    end

    oblm_front #(.SYM_W(SYM_W), .SLOT_W(SLOT_W),
                 .NUM_SYMBOLS(NUM_SYMBOLS), .ORDER_SLOTS(ORDER_SLOTS)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_opcode(s_opcode),
        .s_side_is_ask(s_side_is_ask), .s_symbol_index(s_symbol_index),
        .s_order_slot(s_order_slot), .s_order_size(s_order_size),
        .s_order_price(s_order_price), .s_event_time(s_event_time),
        .c_valid(c_valid), .c_ready(c_ready), .c_pay(c_pay),
        .c_sym(c_sym), .c_slot(c_slot)
    );

    oblm_back #(.SYM_W(SYM_W), .SLOT_W(SLOT_W),
                .NUM_SYMBOLS(NUM_SYMBOLS), .ORDER_SLOTS(ORDER_SLOTS)) u_back (
        .aclk(aclk), .aresetn(aresetn), .tol(tol_reg), .busy(busy),
        .c_valid(c_valid), .c_ready(c_ready), .c_pay(c_pay),
        .c_sym(c_sym), .c_slot(c_slot),
        .m_valid(m_valid), .m_ready(m_ready), .m_report_time(m_report_time),
        .m_report_symbol(m_report_symbol), .m_report_kind(m_report_kind),
        .m_top_bid(m_top_bid), .m_top_ask(m_top_ask)
    );

    a_busy_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> busy) else $error("result without busy");
endmodule
`default_nettype wire

### bench/tb_order_book_cross_lock_monitor.sv
// Testbench for order_book_cross_lock_monitor: directed table, then random order flow.
// Checks every report against an order book predictor kept in this file.
// Depends on oblm_pkg and order_book_cross_lock_monitor.
`timescale 1ns / 1ps
`default_nettype none
module tb_order_book_cross_lock_monitor;

    localparam int SYMS  = 16;
    localparam int SLOTS = 1024;
    localparam int SETTLE = 8 * SLOTS;

    typedef struct {
        logic        op;
        logic        ask_side;
        logic [3:0]  sym;
        logic [9:0]  slot;
        logic [31:0] size;
        logic [31:0] price;
        logic [47:0] stamp;
    } order_evt_t;

    typedef struct {
        logic [47:0] stamp;
        logic [3:0]  sym;
        logic [1:0]  kind;
        logic [31:0] bid;
        logic [31:0] ask;
    } mkt_report_t;

    typedef struct {
        order_evt_t  evt;
        bit          typed;
        mkt_report_t rep;
    } book_row_t;

    logic        aclk;
    logic        aresetn;
    logic        psel, penable, pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid, s_ready;
    logic        s_opcode, s_side_is_ask;
    logic [3:0]  s_symbol_index;
    logic [9:0]  s_order_slot;
    logic [31:0] s_order_size, s_order_price;
    logic [47:0] s_event_time;
    logic        m_valid, m_ready;
    logic [47:0] m_report_time;
    logic [3:0]  m_report_symbol;
    logic [1:0]  m_report_kind;
    logic [31:0] m_top_bid, m_top_ask;

    order_book_cross_lock_monitor dut (.*);

    // book mirror
    bit          bk_live[SLOTS];
    bit          bk_ask[SLOTS];
    logic [3:0]  bk_sym[SLOTS];
    logic [31:0] bk_price[SLOTS];
    bit          sym_alarm[SYMS];
    bit          has_bid[SYMS], has_ask[SYMS];
    logic [31:0] best_bid[SYMS], best_ask[SYMS];
    logic [7:0]  tolerance;

    mkt_report_t pending_reports[$];
    int          errors;
    bit          quiet;
    bit          hold_req;
    book_row_t   rows[13];

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #60ms;
        $display("simulation failed");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
        errors++;
    endtask

    function automatic void refresh_best(input logic [3:0] s);
        has_bid[s] = 0;
        has_ask[s] = 0;
        best_bid[s] = '0;
        best_ask[s] = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (bk_live[i] && bk_sym[i] == s) begin
                if (bk_ask[i]) begin
                    if (!has_ask[s] || bk_price[i] < best_ask[s]) best_ask[s] = bk_price[i];
                    has_ask[s] = 1;
                end else begin
                    if (!has_bid[s] || bk_price[i] > best_bid[s]) best_bid[s] = bk_price[i];
                    has_bid[s] = 1;
                end
            end
        end
    endfunction

    function automatic bit judge_market(input logic [3:0] s, input logic [47:0] t,
                                        output mkt_report_t r);
        bit both;
        logic [32:0] lim;
        both = has_bid[s] && has_ask[s];
        lim = {1'b0, best_bid[s]} + tolerance;
        r = '{t, s, oblm_pkg::KIND_NORMAL, best_bid[s], best_ask[s]};
        if (!sym_alarm[s]) begin
            if (!both) return 0;
            if (best_ask[s] < best_bid[s]) begin
                r.kind = oblm_pkg::KIND_CROSSED;
                sym_alarm[s] = 1;
                return 1;
            end
            if ({1'b0, best_ask[s]} <= lim) begin
                r.kind = oblm_pkg::KIND_LOCKED;
                sym_alarm[s] = 1;
                return 1;
            end
            return 0;
        end
        if (!both || {1'b0, best_ask[s]} > lim) begin
            sym_alarm[s] = 0;
            return 1;
        end
        return 0;
    endfunction

    function automatic bit apply_order(input order_evt_t e, output mkt_report_t r);
        logic [3:0] s;
        if (e.op == oblm_pkg::OP_ADD) begin
            if (bk_live[e.slot] && bk_sym[e.slot] != e.sym) begin
                s = bk_sym[e.slot];
                bk_live[e.slot] = 0;
                refresh_best(s);
            end
            bk_live[e.slot] = 1;
            bk_ask[e.slot] = e.ask_side;
            bk_sym[e.slot] = e.sym;
            bk_price[e.slot] = e.price;
            refresh_best(e.sym);
            return judge_market(e.sym, e.stamp, r);
        end
        if (!bk_live[e.slot]) begin
            r = '{e.stamp, 4'd0, oblm_pkg::KIND_EMPTY, 32'd0, 32'd0};
            return 1;
        end
        s = bk_sym[e.slot];
        if (e.size == 0) bk_live[e.slot] = 0;
        else bk_price[e.slot] = e.price;
        refresh_best(s);
        return judge_market(s, e.stamp, r);
    endfunction

    task automatic send_order(input order_evt_t e, input bit typed, input mkt_report_t want);
        int gap;
        bit hit;
        mkt_report_t r;
        gap = quiet ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_opcode       <= e.op;
        s_side_is_ask  <= e.ask_side;
        s_symbol_index <= e.sym;
        s_order_slot   <= e.slot;
        s_order_size   <= e.size;
        s_order_price  <= e.price;
        s_event_time   <= e.stamp;
        s_valid        <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        hit = apply_order(e, r);
        if (typed) pending_reports.push_back(want);
        else if (hit) pending_reports.push_back(r);
        @(negedge aclk);
    endtask

    task automatic drain_and_set_tolerance(input logic [7:0] v);
        s_valid <= 1'b0;
        wait (pending_reports.size() == 0);
        repeat (SETTLE) @(negedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= 2'(oblm_pkg::REG_PRICE_TOLERANCE * 4);
        pwdata  <= {24'd0, v};
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tolerance = v;
    endtask

    function automatic order_evt_t random_order();
        order_evt_t e;
        int valid_pick;
        e.op       = ($urandom_range(0, 9) < 6) ? oblm_pkg::OP_ADD : oblm_pkg::OP_MODIFY;
        e.ask_side = $urandom_range(0, 1);
        e.sym      = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 3));
        e.slot     = ($urandom_range(0, 7) == 0) ? 10'($urandom) : 10'($urandom_range(0, 63));
        if (e.op == oblm_pkg::OP_MODIFY && $urandom_range(0, 9) != 0) begin
            valid_pick = $urandom_range(0, 63);
            for (int k = 0; k < 64; k++)
                if (bk_live[(valid_pick + k) % 64]) begin
                    e.slot = 10'((valid_pick + k) % 64);
                    break;
                end
        end
        e.size  = ($urandom_range(0, 5) == 0) ? 32'd0 : $urandom;
        e.price = ($urandom_range(0, 15) == 0) ? $urandom : 32'd50000 + $urandom_range(0, 400);
        e.stamp = {16'($urandom), 32'($urandom)};
        return e;
    endfunction

    // receiver
    initial begin
        int n;
        mkt_report_t w;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 0;
                n = 6000;
            end else begin
                n = quiet ? 0 : $urandom_range(0, 17);
            end
            if (n > 0) begin
                m_ready <= 1'b0;
                repeat (n) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            if (pending_reports.size() == 0) begin
                report_mismatch("unexpected report", m_report_time, 0);
            end else begin
                w = pending_reports.pop_front();
                if (m_report_time !== w.stamp) report_mismatch("time", m_report_time, w.stamp);
                if (m_report_symbol !== w.sym) report_mismatch("symbol", m_report_symbol, w.sym);
                if (m_report_kind !== w.kind) report_mismatch("kind", m_report_kind, w.kind);
                if (m_top_bid !== w.bid) report_mismatch("top bid", m_top_bid, w.bid);
                if (m_top_ask !== w.ask) report_mismatch("top ask", m_top_ask, w.ask);
            end
        end
    end

    // stimulus
    initial begin
        mkt_report_t none;
        logic [7:0] tol_plan[4];
        errors = 0;
        quiet = 0;
        hold_req = 0;
        tolerance = '0;
        none = '{48'd0, 4'd0, oblm_pkg::KIND_NORMAL, 32'd0, 32'd0};
        foreach (bk_live[i]) bk_live[i] = 0;
        foreach (sym_alarm[i]) begin
            sym_alarm[i] = 0;
            has_bid[i] = 0;
            has_ask[i] = 0;
            best_bid[i] = '0;
            best_ask[i] = '0;
        end
        aresetn = 1'b0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        s_valid = 0; s_opcode = 0; s_side_is_ask = 0; s_symbol_index = '0;
        s_order_slot = '0; s_order_size = '0; s_order_price = '0; s_event_time = '0;

        rows[0]  = '{'{oblm_pkg::OP_MODIFY, 1'b0, 4'd9, 10'd5, 32'd1, 32'd7, 48'd0}, 1,
                     '{48'd0, 4'd0, oblm_pkg::KIND_EMPTY, 32'd0, 32'd0}};
        rows[1]  = '{'{oblm_pkg::OP_ADD, 1'b0, 4'd3, 10'd0, 32'd1, 32'd1000, 48'd1}, 0,
                     none};
        rows[2]  = '{'{oblm_pkg::OP_ADD, 1'b1, 4'd3, 10'd1023, 32'hFFFFFFFF, 32'd1000,
                       48'd2}, 1,
                     '{48'd2, 4'd3, oblm_pkg::KIND_LOCKED, 32'd1000, 32'd1000}};
        rows[3]  = '{'{oblm_pkg::OP_MODIFY, 1'b0, 4'd0, 10'd1023, 32'd7, 32'd1001, 48'd3}, 1,
                     '{48'd3, 4'd3, oblm_pkg::KIND_NORMAL, 32'd1000, 32'd1001}};
        rows[4]  = '{'{oblm_pkg::OP_MODIFY, 1'b1, 4'd15, 10'd1023, 32'd7, 32'd999, 48'd4}, 1,
                     '{48'd4, 4'd3, oblm_pkg::KIND_CROSSED, 32'd1000, 32'd999}};
        rows[5]  = '{'{oblm_pkg::OP_MODIFY, 1'b0, 4'd0, 10'd1023, 32'd0, 32'd5, 48'd5}, 1,
                     '{48'd5, 4'd3, oblm_pkg::KIND_NORMAL, 32'd1000, 32'd0}};
        rows[6]  = '{'{oblm_pkg::OP_ADD, 1'b1, 4'd15, 10'd512, 32'd0, 32'hFFFFFFFF,
                       48'hFFFFFFFFFFFF}, 0, none};
        rows[7]  = '{'{oblm_pkg::OP_ADD, 1'b0, 4'd15, 10'd513, 32'd3, 32'hFFFFFFFF, 48'd7}, 1,
                     '{48'd7, 4'd15, oblm_pkg::KIND_LOCKED, 32'hFFFFFFFF, 32'hFFFFFFFF}};
        rows[8]  = '{'{oblm_pkg::OP_ADD, 1'b1, 4'd3, 10'd513, 32'd3, 32'd0, 48'd8}, 1,
                     '{48'd8, 4'd3, oblm_pkg::KIND_CROSSED, 32'd1000, 32'd0}};
        rows[9]  = '{'{oblm_pkg::OP_MODIFY, 1'b0, 4'd0, 10'd0, 32'd5, 32'd0, 48'd9}, 0,
                     none};
        rows[10] = '{'{oblm_pkg::OP_MODIFY, 1'b0, 4'd0, 10'd0, 32'd0, 32'd0, 48'd10}, 1,
                     '{48'd10, 4'd3, oblm_pkg::KIND_NORMAL, 32'd0, 32'd0}};
        rows[11] = '{'{oblm_pkg::OP_ADD, 1'b0, 4'd15, 10'd2, 32'd8, 32'd0,
                       48'h800000000000}, 0, none};
        rows[12] = '{'{oblm_pkg::OP_MODIFY, 1'b1, 4'd6, 10'd700, 32'd2, 32'd2, 48'd12}, 1,
                     '{48'd12, 4'd0, oblm_pkg::KIND_EMPTY, 32'd0, 32'd0}};

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        foreach (rows[i]) send_order(rows[i].evt, rows[i].typed, rows[i].rep);

        tol_plan = '{8'd255, 8'd0, 8'($urandom_range(1, 254)), 8'd3};
        for (int p = 0; p < 4; p++) begin
            drain_and_set_tolerance(tol_plan[p]);
            @(negedge aclk);
            if (p == 1) hold_req = 1;
            for (int i = 0; i < 140; i++) begin
                if (i % 35 == 0) quiet = ($urandom_range(0, 3) == 0);
                send_order(random_order(), 0, none);
            end
        end
        quiet = 0;
        s_valid <= 1'b0;

        wait (pending_reports.size() == 0);
        repeat (SETTLE) @(negedge aclk);
        if (pending_reports.size() != 0) errors++;
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

### filelist.f
hw/rtl/oblm_pkg.sv
hw/rtl/oblm_cmd_fifo.sv
hw/rtl/oblm_front.sv
hw/rtl/oblm_back.sv
hw/rtl/order_book_cross_lock_monitor.sv
bench/tb_order_book_cross_lock_monitor.sv
